[hdl/mhcbd_pkg.sv]
// Shared types, constants and helper functions of the Bayer demosaic block.
package mhcbd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int LINE_COUNT    = 4;
    localparam int LINE_SEL_W    = $clog2(LINE_COUNT);
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int CFG_W         = 13;
    localparam int ROW_W         = 13;
    localparam int PIX_W         = 8;
    localparam int WIN_N         = 5;
    localparam int SUM_W         = 15;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic signed [SUM_W-1:0] PIX_MAX_S = 15'sd255;

    // CFA site of the output pixel: {row parity, column parity}
    typedef enum logic [1:0] {
        SITE_GR = 2'd0,
        SITE_R  = 2'd1,
        SITE_B  = 2'd2,
        SITE_GB = 2'd3
    } t_site;

    // column neighbors that lie inside the image
    typedef struct packed {
        logic left2;
        logic left1;
        logic right1;
        logic right2;
    } t_col_ok;

    typedef struct packed {
        logic              valid;
        logic [PIX_W-1:0]  sample;
        logic [WIN_N-1:0]  row_ok;
        logic [LINE_SEL_W-1:0] line;
        logic              emit;
        t_col_ok           col_ok;
        t_site             site;
        logic              eol;
        logic              eof;
    } t_s1;

    typedef struct packed {
        logic    valid;
        t_col_ok col_ok;
        t_site   site;
        logic    eol;
        logic    eof;
    } t_s2;

    // [column group][row], group 0 is the newest column, row 4 the newest row
    typedef logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             eol;
        logic             eof;
    } t_res;

    function automatic logic signed [SUM_W-1:0] tap_val(logic [PIX_W-1:0] v, logic ok);
        return ok ? $signed({{(SUM_W-PIX_W){1'b0}}, v}) : '0;
    endfunction

    // truncating divide by 2**sh, negative sums give zero, saturate at 255
    function automatic logic [PIX_W-1:0] norm_clamp(logic signed [SUM_W-1:0] sum,
                                                    int unsigned sh);
        logic signed [SUM_W-1:0] q;
        q = sum >>> sh;
        if (sum[SUM_W-1]) return '0;
        else if (q > PIX_MAX_S) return '1;
        else return q[PIX_W-1:0];
    endfunction

endpackage

[hdl/mhc_bayer_demosaic.sv]
// Top level: 5x5 Malvar-He-Cutler demosaic for 8-bit GRBG Bayer streams.
//
// Input stream: one raw sample per request, tdata = raw_pixel, tuser = flush.
// Samples arrive in raster order, W per row, H rows (APB registers
// image_width at 0x0, image_height at 0x4; zero is taken as 1, large values
// saturate at MAX_WIDTH and 4096). After the frame, 2*W+2 flush requests
// drain the remaining pixels; flush requests inside the frame are dropped,
// samples sent during the drain are ignored. After the final drain request
// the block starts a new frame.
//
// Output stream: tdata = {blue, green, red}, tlast = end of row,
// tuser = end of frame. The pixel of raster index m leaves with the request
// of index m + 2*W + 2; after that request is taken, its result passes the
// decode and line store read, the window shift and the kernels into the
// output queue, from which it can leave.
//
// Throughput: one request per cycle. A four-entry output queue with credit
// counting keeps tready high while a result waits; tready drops only when
// the queue plus results in flight would overflow, i.e. the receiver stalls.
//
// Reset clears position, window, queue and sets 640x480. The line stores are
// not cleared; reads of lines that hold no image row are forced to zero.
module mhc_bayer_demosaic import mhcbd_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] raw_pixel
    input  logic        i_s_axis_tuser,   // [0] flush
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        o_m_axis_tlast,   // end_of_line
    output logic        o_m_axis_tuser,   // [0] end_of_frame
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    logic [CFG_W-1:0] r_image_width, r_image_height;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             cfg_wr, req;

    logic                  lb_we;
    logic [CW-1:0]         lb_addr;
    logic [LINE_SEL_W-1:0] lb_line;
    logic [PIX_W-1:0]      lb_wdata;
    t_s1                   s1;
    t_s2                   s2;
    t_win                  win;
    t_res                  res, q_res;
    logic [NW-1:0]         fifo_count;
    logic [NW:0]           used;

    // ---------------- configuration registers ----------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (i_paddr[2])
                REG_WIDTH:  r_image_width  <= i_pwdata[CFG_W-1:0];
                REG_HEIGHT: r_image_height <= i_pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_WIDTH:  o_prdata = 32'(r_image_width);
            REG_HEIGHT: o_prdata = 32'(r_image_height);
        endcase
    end

    // effective geometry: zero reads as 1, large values saturate
    always_comb begin
        if (r_image_width == '0) w_eff = WW'(1);
        else if (32'(r_image_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(r_image_width);

        if (r_image_height == '0) h_eff = ROW_W'(1);
        else if (32'(r_image_height) > HEIGHT_LIMIT) h_eff = ROW_W'(HEIGHT_LIMIT);
        else h_eff = ROW_W'(r_image_height);
    end

    // ---------------- flow control ----------------
    // queue entries plus results still in the two pipeline stages
    assign used = (NW+1)'(fifo_count) + (NW+1)'(s1.valid && s1.emit) + (NW+1)'(s2.valid);
    assign o_s_axis_tready = used < (NW+1)'(FIFO_DEPTH);
    assign req = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- datapath ----------------
    mhcbd_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_flush  (i_s_axis_tuser),
        .i_pixel  (i_s_axis_tdata),
        .i_width  (w_eff),
        .i_height (h_eff),
        .o_we     (lb_we),
        .o_addr   (lb_addr),
        .o_line   (lb_line),
        .o_wdata  (lb_wdata),
        .o_s1     (s1)
    );

    mhcbd_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (lb_we),
        .i_addr  (lb_addr),
        .i_line  (lb_line),
        .i_wdata (lb_wdata),
        .i_s1    (s1),
        .o_win   (win),
        .o_s2    (s2)
    );

    mhcbd_kernel u_kernel (
        .i_win (win),
        .i_s2  (s2),
        .o_res (res)
    );

    mhcbd_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s2.valid),
        .i_data  (res),
        .i_pop   (i_m_axis_tready),
        .o_data  (q_res),
        .o_valid (o_m_axis_tvalid),
        .o_count (fifo_count)
    );

    assign o_m_axis_tdata = {q_res.blue, q_res.green, q_res.red};
    assign o_m_axis_tlast = q_res.eol;
    assign o_m_axis_tuser = q_res.eof;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= (NW+1)'(FIFO_DEPTH))
        else $error("results in flight exceed queue space");

    a_eof_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("end of frame without end of line");

endmodule

[hdl/mhcbd_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
module mhcbd_ram import mhcbd_pkg::*; #(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mhcbd_scan.sv]
// Raster position tracking, phase decode and line store addressing.
module mhcbd_scan import mhcbd_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req,
    input  logic                  i_flush,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic [WW-1:0]         i_width,
    input  logic [ROW_W-1:0]      i_height,
    output logic                  o_we,
    output logic [CW-1:0]         o_addr,
    output logic [LINE_SEL_W-1:0] o_line,
    output logic [PIX_W-1:0]      o_wdata,
    output t_s1                   o_s1
);

    localparam int XW = WW + 1;

    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    t_s1              r_s1, n_s1;

    logic [ROW_W-1:0] row_last, row_c, prow_c, start_row;
    logic [CW-1:0]    col_last, col_c, pcol_c, start_col;
    logic             beyond, restart, pix_phase, take, emit, is_last;
    logic [PIX_W-1:0] sample;
    logic [WIN_N-1:0] row_ok;

    always_comb begin
        // final drain item sits at index (H+2)*W+1
        row_last = (i_width == WW'(1)) ? i_height + ROW_W'(3) : i_height + ROW_W'(2);
        col_last = (i_width == WW'(1)) ? '0 : CW'(1);
        // first result comes with item index 2*W+2
        if (i_width >= WW'(3)) begin
            start_row = ROW_W'(2);
            start_col = CW'(2);
        end else if (i_width == WW'(2)) begin
            start_row = ROW_W'(3);
            start_col = '0;
        end else begin
            start_row = ROW_W'(4);
            start_col = '0;
        end

        beyond  = (r_row > row_last) || ((r_row == row_last) && (r_col > col_last));
        restart = (XW'(r_col) >= XW'(i_width)) || beyond;
        row_c   = restart ? '0 : r_row;
        col_c   = restart ? '0 : r_col;

        // output pixel sits 2*W+2 items behind the input position
        if (i_width == WW'(1)) begin
            prow_c = row_c - ROW_W'(4);
            pcol_c = '0;
        end else if (col_c >= CW'(2)) begin
            prow_c = row_c - ROW_W'(2);
            pcol_c = col_c - CW'(2);
        end else begin
            prow_c = row_c - ROW_W'(3);
            pcol_c = CW'(XW'(i_width) + XW'(col_c) - XW'(2));
        end

        pix_phase = row_c < i_height;
        take      = i_req && !(pix_phase && i_flush);   // flush inside the frame is dropped
        sample    = pix_phase ? i_pixel : '0;
        emit      = (row_c > start_row) || ((row_c == start_row) && (col_c >= start_col));
        is_last   = (row_c == row_last) && (col_c == col_last);

        for (int i = 0; i < WIN_N - 1; i++) begin
            row_ok[i] = (row_c >= ROW_W'(LINE_COUNT - i))
                     && ((row_c - ROW_W'(LINE_COUNT - i)) < i_height);
        end
        row_ok[WIN_N-1] = pix_phase;

        n_s1.valid  = take;
        n_s1.sample = sample;
        n_s1.row_ok = row_ok;
        n_s1.line   = row_c[LINE_SEL_W-1:0];
        n_s1.emit   = emit;
        n_s1.col_ok.left2  = pcol_c >= CW'(2);
        n_s1.col_ok.left1  = pcol_c != '0;
        n_s1.col_ok.right1 = (XW'(pcol_c) + XW'(1)) < XW'(i_width);
        n_s1.col_ok.right2 = (XW'(pcol_c) + XW'(2)) < XW'(i_width);
        n_s1.site   = t_site'({prow_c[0], pcol_c[0]});
        n_s1.eol    = emit && (XW'(pcol_c) + XW'(1) == XW'(i_width));
        n_s1.eof    = n_s1.eol && (prow_c + ROW_W'(1) == i_height);

        // a dropped flush still restarts a stale position
        n_row = i_req ? row_c : r_row;
        n_col = i_req ? col_c : r_col;
        if (take) begin
            if (is_last) begin
                n_row = '0;
                n_col = '0;
            end else begin
                if (XW'(col_c) + XW'(1) >= XW'(i_width)) begin
                    n_col = '0;
                    n_row = row_c + ROW_W'(1);
                end else begin
                    n_col = col_c + CW'(1);
                    n_row = row_c;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_s1   <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_s1   <= n_s1;
        end
    end

    // line store: read all lines at the column, overwrite the oldest line
    assign o_we    = take;
    assign o_addr  = col_c;
    assign o_line  = row_c[LINE_SEL_W-1:0];
    assign o_wdata = sample;
    assign o_s1    = r_s1;

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && is_last |=> (r_row == '0) && (r_col == '0))
        else $error("position not cleared after final drain request");

endmodule

[hdl/mhcbd_window.sv]
// Four line stores and the 5x5 sample window.
module mhcbd_window import mhcbd_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CW-1:0]         i_addr,
    input  logic [LINE_SEL_W-1:0] i_line,
    input  logic [PIX_W-1:0]      i_wdata,
    input  t_s1                   i_s1,
    output t_win                  o_win,
    output t_s2                   o_s2
);

    logic [PIX_W-1:0] rd [LINE_COUNT];
    logic [WIN_N-1:0][PIX_W-1:0] col_new;
    t_win r_win;
    t_s2  r_s2;

    for (genvar g = 0; g < LINE_COUNT; g++) begin : g_line
        mhcbd_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (i_we && (i_line == LINE_SEL_W'(g))),
            .i_waddr (i_addr),
            .i_wdata (i_wdata),
            .i_raddr (i_addr),
            .o_rdata (rd[g])
        );
    end

    // row i of the new column comes from line (row + i) mod 4, rows off the image read zero
    always_comb begin
        for (int i = 0; i < WIN_N - 1; i++) begin
            col_new[i] = i_s1.row_ok[i] ? rd[LINE_SEL_W'(i_s1.line + LINE_SEL_W'(i))] : '0;
        end
        col_new[WIN_N-1] = i_s1.row_ok[WIN_N-1] ? i_s1.sample : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_s2  <= '0;
        end else begin
            if (i_s1.valid) begin
                r_win[0] <= col_new;
                for (int k = 1; k < WIN_N; k++) begin
                    r_win[k] <= r_win[k-1];
                end
            end
            r_s2.valid  <= i_s1.valid && i_s1.emit;
            r_s2.col_ok <= i_s1.col_ok;
            r_s2.site   <= i_s1.site;
            r_s2.eol    <= i_s1.eol;
            r_s2.eof    <= i_s1.eof;
        end
    end

    assign o_win = r_win;
    assign o_s2  = r_s2;

endmodule

[hdl/mhcbd_kernel.sv]
// Malvar-He-Cutler 5x5 kernels and per-site color selection.
module mhcbd_kernel import mhcbd_pkg::*; (
    input  t_win i_win,
    input  t_s2  i_s2,
    output t_res o_res
);

    logic signed [SUM_W-1:0] c, u, d, l, r, diag, vv, hh;
    logic signed [SUM_W-1:0] sum_h, sum_v, sum_g, sum_x;
    logic [PIX_W-1:0] kh, kv, kg, kx, cc;

    always_comb begin
        c = tap_val(i_win[2][2], 1'b1);
        u = tap_val(i_win[2][1], 1'b1);
        d = tap_val(i_win[2][3], 1'b1);
        l = tap_val(i_win[3][2], i_s2.col_ok.left1);
        r = tap_val(i_win[1][2], i_s2.col_ok.right1);
        diag = tap_val(i_win[3][1], i_s2.col_ok.left1)
             + tap_val(i_win[1][1], i_s2.col_ok.right1)
             + tap_val(i_win[3][3], i_s2.col_ok.left1)
             + tap_val(i_win[1][3], i_s2.col_ok.right1);
        vv = tap_val(i_win[2][0], 1'b1) + tap_val(i_win[2][4], 1'b1);
        hh = tap_val(i_win[4][2], i_s2.col_ok.left2)
           + tap_val(i_win[0][2], i_s2.col_ok.right2);

        // green site, horizontal / vertical neighbor color
        sum_h = 15'sd10 * c + ((l + r) <<< 3) - (diag <<< 1) + vv - (hh <<< 1);
        sum_v = 15'sd10 * c + ((u + d) <<< 3) - (diag <<< 1) - (vv <<< 1) + hh;
        // green at a red or blue site
        sum_g = (c <<< 2) + ((u + d + l + r) <<< 1) - vv - hh;
        // red at blue, blue at red
        sum_x = 15'sd12 * c + (diag <<< 2) - 15'sd3 * (vv + hh);

        kh = norm_clamp(sum_h, 4);
        kv = norm_clamp(sum_v, 4);
        kg = norm_clamp(sum_g, 3);
        kx = norm_clamp(sum_x, 4);
        cc = i_win[2][2];

        o_res.eol = i_s2.eol;
        o_res.eof = i_s2.eof;
        case (i_s2.site)
            SITE_GR: begin
                o_res.red   = kh;
                o_res.green = cc;
                o_res.blue  = kv;
            end
            SITE_R: begin
                o_res.red   = cc;
                o_res.green = kg;
                o_res.blue  = kx;
            end
            SITE_B: begin
                o_res.red   = kx;
                o_res.green = kg;
                o_res.blue  = cc;
            end
            default: begin
                o_res.red   = kv;
                o_res.green = cc;
                o_res.blue  = kh;
            end
        endcase
    end

endmodule

[hdl/mhcbd_out_fifo.sv]
// Small output queue that decouples the result pipeline from the receiver.
module mhcbd_out_fifo import mhcbd_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH,
    localparam int PW = $clog2(DEPTH),
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_res          i_data,
    input  logic          i_pop,
    output t_res          o_data,
    output logic          o_valid,
    output logic [NW-1:0] o_count
);

    t_res          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [NW-1:0] r_count;
    logic          pop_ok;

    assign o_valid = r_count != '0;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop_ok |-> r_count < NW'(DEPTH))
        else $error("result pushed into a full queue");

endmodule
